@@ sv/charger_sequence_fault_monitor_assert.svh @@
// Assertion macros for the charger sequence fault monitor.
// Expects clk_i and rst_ni in the scope of use.
`ifndef CHARGER_SEQUENCE_FAULT_MONITOR_ASSERT_SVH
`define CHARGER_SEQUENCE_FAULT_MONITOR_ASSERT_SVH

// same-cycle implication
`define CSFM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("csfm: same-cycle check failed");

// next-cycle implication
`define CSFM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("csfm: next-cycle check failed");

`endif

@@ sv/csfm_pkg.sv @@
// Package for the charger sequence fault monitor: codes, reset values, defaults.
// No dependencies.
package csfm_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned CFG_IDX_W        = 3;
  localparam int unsigned CFG_DATA_W       = 16;
  localparam int unsigned TIMER_W          = 17;
  localparam int unsigned RAMP_W           = 8;
  localparam int unsigned SUM_OUT_W        = 17;

  localparam logic [14:0] OVER_CURRENT_RST  = 15'd800;
  localparam logic [15:0] OVER_VOLTAGE_RST  = 16'sd4000;
  localparam logic [15:0] UNDER_CURRENT_RST = -16'sd80;
  localparam logic [15:0] TIME_LIMIT_RST    = 16'd3600;
  localparam logic [7:0]  RAMP_LENGTH_RST   = 8'd100;

  localparam logic [1:0] PLUG_NONE = 2'd0;
  localparam logic [1:0] PLUG_PAID = 2'd2;

  typedef enum logic [1:0] {
    LVL_NORMAL  = 2'd0,
    LVL_DETECT  = 2'd1,
    LVL_CONFIRM = 2'd2
  } fault_level_e;

  typedef enum logic [1:0] {
    CODE_NONE          = 2'd0,
    CODE_OVER_CURRENT  = 2'd1,
    CODE_OVER_VOLTAGE  = 2'd2,
    CODE_UNDER_CURRENT = 2'd3
  } fault_code_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVER_CURRENT  = 3'd0,
    REG_OVER_VOLTAGE  = 3'd1,
    REG_UNDER_CURRENT = 3'd2,
    REG_TIME_LIMIT    = 3'd3,
    REG_RAMP_LENGTH   = 3'd4
  } cfg_index_e;

endpackage

@@ sv/csfm_if.sv @@
// Channel interfaces for the charger sequence fault monitor: tick, result, config.
// Depends on csfm_pkg.
interface csfm_req_if
  import csfm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [1:0]                     plug_status;
  logic signed [SAMPLE_WIDTH-1:0] current_a;
  logic signed [SAMPLE_WIDTH-1:0] current_b;
  logic signed [SAMPLE_WIDTH-1:0] current_c;
  logic signed [SAMPLE_WIDTH-1:0] voltage_a;

  modport source (output valid, plug_status, current_a, current_b, current_c, voltage_a,
                  input ready);
  modport sink (input valid, plug_status, current_a, current_b, current_c, voltage_a,
                output ready);
endinterface

interface csfm_rsp_if
  import csfm_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [2:0]           next_state;
  logic                 stop_flag;
  logic                 relay_on;
  logic [1:0]           fault_level;
  logic [1:0]           fault_code;
  logic [RAMP_W-1:0]    ramp_count;
  logic [TIMER_W-1:0]   charge_time;
  logic [SUM_OUT_W-1:0] current_sum;

  modport source (output valid, next_state, stop_flag, relay_on, fault_level, fault_code,
                  ramp_count, charge_time, current_sum, input ready);
  modport sink (input valid, next_state, stop_flag, relay_on, fault_level, fault_code,
                ramp_count, charge_time, current_sum, output ready);
endinterface

interface csfm_cfg_if
  import csfm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/charger_sequence_fault_monitor.sv @@
// Charger sequence fault monitor: protection check and six-state charge sequencer.
// Depends on csfm_pkg, csfm_if.sv and charger_sequence_fault_monitor_assert.svh.
//
//   port    dir   carries
//   req_i   in    tick: plug status, three phase currents, phase-A voltage
//   rsp_o   out   result: next state, relay/stop, fault level and code, counters, sum
//   cfg_i   in    register writes, index and data
//
// One tick per cycle sustained while results are taken; a tick passes the input register,
// then the result register, before its result is valid.
// The state update of the sequencer sets the rate. A stalled result
// holds the result register and, behind it, the input register; ready drops only when both are full.
// Reset clears state, counters and limits to their defaults.
`include "charger_sequence_fault_monitor_assert.svh"

module charger_sequence_fault_monitor
  import csfm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  csfm_req_if.sink   req_i,
  csfm_rsp_if.source rsp_o,
  csfm_cfg_if.sink   cfg_i
);

  localparam int unsigned SUM_W = SAMPLE_WIDTH + 2;
  localparam int unsigned CMP_W = ((SUM_W > 18) ? SUM_W : 18) + 1;
  localparam int unsigned VLT_W = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

  typedef enum logic [2:0] {
    ST_INIT     = 3'd0,
    ST_WAIT     = 3'd1,
    ST_CHARGING = 3'd2,
    ST_FAULT    = 3'd3,
    ST_RESET    = 3'd4,
    ST_SHUTDOWN = 3'd5
  } seq_state_e;

  logic [14:0]        ocl_q;
  logic signed [15:0] ovl_q;
  logic signed [15:0] ucl_q;
  logic [15:0]        tlim_q;
  logic [7:0]         rlen_q;

  logic                           in_valid_q;
  logic [1:0]                     plug_q;
  logic signed [SAMPLE_WIDTH-1:0] ia_q, ib_q, ic_q, va_q;

  seq_state_e         seq_q, seq_d;
  fault_level_e       lvl_q, lvl_d;
  fault_code_e        code_q, code_d;
  logic [RAMP_W-1:0]  ramp_q, ramp_d;
  logic [TIMER_W-1:0] timer_q, timer_d;

  logic                 out_valid_q;
  logic                 stop_q, stop_d;
  logic                 relay_q, relay_d;
  logic [SUM_OUT_W-1:0] osum_q;

  logic                     adv;
  logic [SAMPLE_WIDTH-1:0]  ma, mb, mc;
  logic [SUM_W-1:0]         sum;
  logic signed [CMP_W-1:0]  sum_s, oc3_s, uc3_s;
  logic [16:0]              oc3;
  logic signed [17:0]       uc3;
  logic signed [VLT_W-1:0]  va_s, ovl_s;
  logic                     charging;
  fault_level_e             lvl_p;
  fault_code_e              code_p;
  logic [TIMER_W-1:0]       timer_inc;

  assign adv         = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocl_q  <= OVER_CURRENT_RST;
      ovl_q  <= OVER_VOLTAGE_RST;
      ucl_q  <= UNDER_CURRENT_RST;
      tlim_q <= TIME_LIMIT_RST;
      rlen_q <= RAMP_LENGTH_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_OVER_CURRENT:  ocl_q  <= cfg_i.data[14:0];
        REG_OVER_VOLTAGE:  ovl_q  <= cfg_i.data;
        REG_UNDER_CURRENT: ucl_q  <= cfg_i.data;
        REG_TIME_LIMIT:    tlim_q <= cfg_i.data;
        REG_RAMP_LENGTH:   rlen_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      plug_q <= req_i.plug_status;
      ia_q   <= req_i.current_a;
      ib_q   <= req_i.current_b;
      ic_q   <= req_i.current_c;
      va_q   <= req_i.voltage_a;
    end
  end

  always_comb begin
    ma    = ia_q[SAMPLE_WIDTH-1] ? (~ia_q + 1'b1) : ia_q;
    mb    = ib_q[SAMPLE_WIDTH-1] ? (~ib_q + 1'b1) : ib_q;
    mc    = ic_q[SAMPLE_WIDTH-1] ? (~ic_q + 1'b1) : ic_q;
    sum   = SUM_W'(ma) + SUM_W'(mb) + SUM_W'(mc);
    oc3   = {2'b00, ocl_q} + {1'b0, ocl_q, 1'b0};
    uc3   = {{2{ucl_q[15]}}, ucl_q} + {ucl_q[15], ucl_q, 1'b0};
    sum_s = signed'(CMP_W'(sum));
    oc3_s = signed'(CMP_W'(oc3));
    uc3_s = CMP_W'(uc3);
    va_s  = VLT_W'(va_q);
    ovl_s = VLT_W'(ovl_q);
  end

  always_comb begin
    charging  = (seq_q == ST_CHARGING);
    lvl_p     = lvl_q;
    code_p    = code_q;
    timer_inc = (timer_q != '1) ? (timer_q + 1'b1) : timer_q;

    if (lvl_q == LVL_NORMAL && charging) begin
      if (sum_s > oc3_s) begin
        code_p = CODE_OVER_CURRENT;
        lvl_p  = LVL_CONFIRM;
      end else if (va_s > ovl_s) begin
        code_p = CODE_OVER_VOLTAGE;
        lvl_p  = LVL_CONFIRM;
      end else if (sum_s < uc3_s) begin
        code_p = CODE_UNDER_CURRENT;
        lvl_p  = LVL_DETECT;
      end
    end
    if (lvl_p == LVL_DETECT && sum_s < oc3_s && sum != '0) begin
      lvl_p  = LVL_NORMAL;
      code_p = CODE_NONE;
    end

    seq_d   = seq_q;
    lvl_d   = lvl_p;
    code_d  = code_p;
    ramp_d  = ramp_q;
    timer_d = timer_q;
    stop_d  = 1'b1;
    relay_d = 1'b0;

    unique case (seq_q)
      ST_INIT: begin
        lvl_d   = LVL_NORMAL;
        code_d  = CODE_NONE;
        timer_d = '0;
        ramp_d  = '0;
        if (plug_q != PLUG_NONE) seq_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (plug_q == PLUG_NONE) begin
          seq_d = ST_INIT;
        end else if (plug_q == PLUG_PAID && lvl_p == LVL_NORMAL) begin
          seq_d  = ST_CHARGING;
          ramp_d = '0;
        end
      end
      ST_CHARGING: begin
        stop_d  = 1'b0;
        relay_d = 1'b1;
        timer_d = timer_inc;
        if (ramp_q < rlen_q) ramp_d = ramp_q + 1'b1;
        if (plug_q == PLUG_NONE) begin
          seq_d = ST_SHUTDOWN;
        end else if (timer_inc > {1'b0, tlim_q}) begin
          seq_d = ST_SHUTDOWN;
        end else if (lvl_p == LVL_CONFIRM) begin
          seq_d = ST_FAULT;
        end
      end
      ST_FAULT: begin
        seq_d = ST_RESET;
      end
      ST_RESET: begin
        if (lvl_p == LVL_NORMAL) seq_d = ST_INIT;
      end
      ST_SHUTDOWN: begin
        ramp_d = '0;
        if (plug_q == PLUG_NONE) seq_d = ST_INIT;
      end
      default: begin
        seq_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= ST_INIT;
      lvl_q       <= LVL_NORMAL;
      code_q      <= CODE_NONE;
      ramp_q      <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
      stop_q      <= 1'b1;
      relay_q     <= 1'b0;
      osum_q      <= '0;
    end else begin
      if (adv) begin
        seq_q   <= seq_d;
        lvl_q   <= lvl_d;
        code_q  <= code_d;
        ramp_q  <= ramp_d;
        timer_q <= timer_d;
        stop_q  <= stop_d;
        relay_q <= relay_d;
        osum_q  <= sum_s[SUM_OUT_W-1:0];
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.next_state  = seq_q;
  assign rsp_o.stop_flag   = stop_q;
  assign rsp_o.relay_on    = relay_q;
  assign rsp_o.fault_level = lvl_q;
  assign rsp_o.fault_code  = code_q;
  assign rsp_o.ramp_count  = ramp_q;
  assign rsp_o.charge_time = timer_q;
  assign rsp_o.current_sum = osum_q;

  `CSFM_ASSERT_NOW(a_confirm_code, lvl_q == LVL_CONFIRM,
                   code_q == CODE_OVER_CURRENT || code_q == CODE_OVER_VOLTAGE)
  `CSFM_ASSERT_NOW(a_normal_code, lvl_q == LVL_NORMAL, code_q == CODE_NONE)
  `CSFM_ASSERT_NEXT(a_fault_to_reset, adv && seq_q == ST_FAULT, seq_q == ST_RESET)
  `CSFM_ASSERT_NOW(a_relay_charging, out_valid_q && relay_q, !stop_q)

endmodule

@@ dv/charger_sequence_fault_monitor_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for charger_sequence_fault_monitor: a directed table, partly with pinned results,
// then randomized charging sessions under several limit settings, scored against an in-bench sequencer model.
// Depends on csfm_pkg, csfm_if.sv and the block's RTL.
module charger_sequence_fault_monitor_tb;
  import csfm_pkg::*;

  localparam logic [2:0] ST_INIT     = 3'd0;
  localparam logic [2:0] ST_WAIT     = 3'd1;
  localparam logic [2:0] ST_CHARGING = 3'd2;
  localparam logic [2:0] ST_FAULT    = 3'd3;
  localparam logic [2:0] ST_RESET    = 3'd4;
  localparam logic [2:0] ST_SHUTDOWN = 3'd5;

  localparam logic [1:0] PLUG_UNPAID = 2'd1;
  localparam logic [1:0] PLUG_ODD    = 2'd3;

  localparam logic [16:0] TIMER_TOP   = 17'h1FFFF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 200;
  localparam int          LATCH_ITEMS = 150;

  typedef struct {
    logic [1:0]         plug;
    logic signed [15:0] cur_a;
    logic signed [15:0] cur_b;
    logic signed [15:0] cur_c;
    logic signed [15:0] volt_a;
  } tick_t;

  typedef struct {
    logic [2:0]   next_state;
    logic         stop_flag;
    logic         relay_on;
    fault_level_e level;
    fault_code_e  code;
    logic [7:0]   ramp;
    logic [16:0]  timer;
    logic [16:0]  sum;
  } tick_result_t;

  typedef enum {ROW_TICK, ROW_PINNED, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e    kind;
    tick_t        tick;
    tick_result_t want;
    cfg_index_e   reg_idx;
    logic [15:0]  reg_val;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  csfm_req_if req_if ();
  csfm_rsp_if rsp_if ();
  csfm_cfg_if cfg_if ();

  charger_sequence_fault_monitor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  logic [14:0]        oc_lim;
  logic signed [15:0] ov_lim;
  logic signed [15:0] uc_lim;
  logic [15:0]        time_lim;
  logic [7:0]         ramp_len;
  logic [2:0]         seq;
  fault_level_e       lvl;
  fault_code_e        code;
  logic [7:0]         ramp_cnt;
  logic [16:0]        chg_timer;

  tick_result_t pending_results[$];
  dir_row_t     directed_rows[$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  cycles;
  bit           tx_quiet;
  bit           rx_quiet;
  logic [1:0]   plug_now;

  function automatic void reset_charger_model();
    oc_lim    = OVER_CURRENT_RST;
    ov_lim    = OVER_VOLTAGE_RST;
    uc_lim    = UNDER_CURRENT_RST;
    time_lim  = TIME_LIMIT_RST;
    ramp_len  = RAMP_LENGTH_RST;
    seq       = ST_INIT;
    lvl       = LVL_NORMAL;
    code      = CODE_NONE;
    ramp_cnt  = '0;
    chg_timer = '0;
  endfunction

  function automatic void apply_write(cfg_index_e idx, logic [15:0] val);
    case (idx)
      REG_OVER_CURRENT:  oc_lim = val[14:0];
      REG_OVER_VOLTAGE:  ov_lim = val;
      REG_UNDER_CURRENT: uc_lim = val;
      REG_TIME_LIMIT:    time_lim = val;
      REG_RAMP_LENGTH:   ramp_len = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic int magnitude(logic signed [15:0] x);
    return (x < 0) ? -int'(x) : int'(x);
  endfunction

  function automatic tick_result_t advance_charger(tick_t t);
    tick_result_t r;
    int           sum;
    int           oc3;
    int           uc3;
    logic         in_charge;
    sum       = magnitude(t.cur_a) + magnitude(t.cur_b) + magnitude(t.cur_c);
    oc3       = 3 * int'(oc_lim);
    uc3       = 3 * int'(uc_lim);
    in_charge = (seq == ST_CHARGING);
    r.stop_flag = 1'b1;
    r.relay_on  = 1'b0;
    if (lvl == LVL_NORMAL && in_charge) begin
      if (sum > oc3) begin
        code = CODE_OVER_CURRENT;
        lvl  = LVL_CONFIRM;
      end else if (int'(t.volt_a) > int'(ov_lim)) begin
        code = CODE_OVER_VOLTAGE;
        lvl  = LVL_CONFIRM;
      end else if (sum < uc3) begin
        code = CODE_UNDER_CURRENT;
        lvl  = LVL_DETECT;
      end
    end
    if (lvl == LVL_DETECT && sum < oc3 && sum > 0) begin
      lvl  = LVL_NORMAL;
      code = CODE_NONE;
    end
    case (seq)
      ST_INIT: begin
        lvl       = LVL_NORMAL;
        code      = CODE_NONE;
        chg_timer = '0;
        ramp_cnt  = '0;
        if (t.plug != PLUG_NONE) seq = ST_WAIT;
      end
      ST_WAIT: begin
        if (t.plug == PLUG_NONE) begin
          seq = ST_INIT;
        end else if (t.plug == PLUG_PAID && lvl == LVL_NORMAL) begin
          seq      = ST_CHARGING;
          ramp_cnt = '0;
        end
      end
      ST_CHARGING: begin
        r.stop_flag = 1'b0;
        r.relay_on  = 1'b1;
        if (ramp_cnt < ramp_len) ramp_cnt++;
        if (chg_timer < TIMER_TOP) chg_timer++;
        if (t.plug == PLUG_NONE) seq = ST_SHUTDOWN;
        else if (chg_timer > {1'b0, time_lim}) seq = ST_SHUTDOWN;
        else if (lvl == LVL_CONFIRM) seq = ST_FAULT;
      end
      ST_FAULT: seq = ST_RESET;
      ST_RESET: begin
        if (lvl == LVL_NORMAL) seq = ST_INIT;
      end
      ST_SHUTDOWN: begin
        ramp_cnt = '0;
        if (t.plug == PLUG_NONE) seq = ST_INIT;
      end
      default: seq = ST_INIT;
    endcase
    r.next_state = seq;
    r.level      = lvl;
    r.code       = code;
    r.ramp       = ramp_cnt;
    r.timer      = chg_timer;
    r.sum        = sum[16:0];
    return r;
  endfunction

  function automatic logic signed [15:0] signed_draw(int top);
    int m;
    m = int'($urandom_range(0, top));
    return ($urandom_range(0, 1) != 0) ? 16'(-m) : 16'(m);
  endfunction

  function automatic logic signed [15:0] draw_current();
    int top;
    top = (int'(oc_lim) + 32 > 32767) ? 32767 : int'(oc_lim) + 32;
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return signed_draw(64);
      2: return signed_draw(top);
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [15:0] draw_voltage();
    int v;
    case ($urandom_range(0, 2))
      0: return 16'($urandom);
      1: v = int'(ov_lim) + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, 8000));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [1:0] draw_plug();
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 9))
        0, 1: plug_now = PLUG_NONE;
        2: plug_now = PLUG_UNPAID;
        3: plug_now = PLUG_ODD;
        default: plug_now = PLUG_PAID;
      endcase
    end
    if ($urandom_range(0, 24) == 0) return 2'($urandom);
    return plug_now;
  endfunction

  // keep a normal charging tick clear of any trip that would latch the sequencer
  function automatic tick_t tame_tick(tick_t t);
    if (seq == ST_CHARGING && lvl == LVL_NORMAL) begin
      if (int'(t.volt_a) > int'(ov_lim)) t.volt_a = ov_lim;
      if (magnitude(t.cur_a) + magnitude(t.cur_b) + magnitude(t.cur_c) > 3 * int'(oc_lim)) begin
        t.cur_a = signed_draw(int'(oc_lim));
        t.cur_b = signed_draw(int'(oc_lim));
        t.cur_c = signed_draw(int'(oc_lim));
      end
    end
    return t;
  endfunction

  function automatic dir_row_t tick_row(logic [1:0] plug, int a, int b, int c, int v);
    dir_row_t row;
    row.kind        = ROW_TICK;
    row.tick.plug   = plug;
    row.tick.cur_a  = 16'(a);
    row.tick.cur_b  = 16'(b);
    row.tick.cur_c  = 16'(c);
    row.tick.volt_a = 16'(v);
    return row;
  endfunction

  function automatic dir_row_t pinned_row(logic [1:0] plug, int a, int b, int c, int v,
                                          logic [2:0] ns, logic stop, logic relay,
                                          fault_level_e lv, fault_code_e cd,
                                          int ramp, int timer, int sum);
    dir_row_t row;
    row                 = tick_row(plug, a, b, c, v);
    row.kind            = ROW_PINNED;
    row.want.next_state = ns;
    row.want.stop_flag  = stop;
    row.want.relay_on   = relay;
    row.want.level      = lv;
    row.want.code       = cd;
    row.want.ramp       = 8'(ramp);
    row.want.timer      = 17'(timer);
    row.want.sum        = 17'(sum);
    return row;
  endfunction

  function automatic dir_row_t write_row(cfg_index_e idx, logic [15:0] val);
    dir_row_t row;
    row         = tick_row(PLUG_NONE, 0, 0, 0, 0);
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [16:0] got, logic [16:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                              results_seen, name, got, want));
  endtask

  task automatic check_result();
    tick_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = pending_results.pop_front();
    compare_field("next_state", 17'(rsp_if.next_state), 17'(want.next_state));
    compare_field("stop_flag", 17'(rsp_if.stop_flag), 17'(want.stop_flag));
    compare_field("relay_on", 17'(rsp_if.relay_on), 17'(want.relay_on));
    compare_field("fault_level", 17'(rsp_if.fault_level), 17'(want.level));
    compare_field("fault_code", 17'(rsp_if.fault_code), 17'(want.code));
    compare_field("ramp_count", 17'(rsp_if.ramp_count), 17'(want.ramp));
    compare_field("charge_time", rsp_if.charge_time, want.timer);
    compare_field("current_sum", rsp_if.current_sum, want.sum);
  endtask

  task automatic send_tick(tick_t t, tick_result_t want);
    int gap;
    gap = tx_quiet ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.plug_status <= t.plug;
    req_if.current_a   <= t.cur_a;
    req_if.current_b   <= t.cur_b;
    req_if.current_c   <= t.cur_c;
    req_if.voltage_a   <= t.volt_a;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(want);
  endtask

  // hold the tick channel until every outstanding result is back
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_write(idx, val);
  endtask

  task automatic configure_phase(int p);
    logic [15:0] oc_v;
    logic [15:0] ov_v;
    logic [15:0] uc_v;
    logic [15:0] tl_v;
    logic [15:0] rl_v;
    if (p == 0) begin
      oc_v = 16'h0000; ov_v = 16'h8000; uc_v = 16'h8000; tl_v = 16'h0000; rl_v = 16'h0000;
    end else if (p == 1) begin
      oc_v = 16'hFFFF; ov_v = 16'h7FFF; uc_v = 16'h7FFF; tl_v = 16'hFFFF; rl_v = 16'h00FF;
    end else if (p == PHASES) begin
      oc_v = 16'($urandom_range(100, 1500));
      ov_v = 16'($urandom_range(0, 8000));
      uc_v = signed_draw(200);
      tl_v = 16'($urandom_range(20, 200));
      rl_v = 16'($urandom_range(0, 255));
    end else begin
      oc_v = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 2000)) : 16'($urandom);
      oc_v[15] = 1'($urandom);
      ov_v = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 8000)) : 16'($urandom);
      uc_v = ($urandom_range(0, 1) != 0) ? signed_draw(300) : 16'($urandom);
      tl_v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 80));
      rl_v = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
    end
    settle();
    write_reg(REG_OVER_CURRENT, oc_v);
    write_reg(REG_OVER_VOLTAGE, ov_v);
    write_reg(REG_UNDER_CURRENT, uc_v);
    write_reg(REG_TIME_LIMIT, tl_v);
    write_reg(REG_RAMP_LENGTH, rl_v);
    cfg_if.valid <= 1'b0;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_items(int count, bit tamed);
    tick_t        t;
    tick_result_t r;
    for (int n = 0; n < count; n++) begin
      t.plug   = draw_plug();
      t.cur_a  = draw_current();
      t.cur_b  = draw_current();
      t.cur_c  = draw_current();
      t.volt_a = draw_voltage();
      if (tamed) t = tame_tick(t);
      r = advance_charger(t);
      send_tick(t, r);
      if ($urandom_range(0, 149) == 0) settle();
    end
  endtask

  task automatic build_directed();
    directed_rows.push_back(pinned_row(PLUG_NONE, 0, 0, 0, 0,
                            ST_INIT, 1, 0, LVL_NORMAL, CODE_NONE, 0, 0, 0));
    directed_rows.push_back(pinned_row(PLUG_UNPAID, 32767, 0, 0, 0,
                            ST_WAIT, 1, 0, LVL_NORMAL, CODE_NONE, 0, 0, 32767));
    directed_rows.push_back(pinned_row(PLUG_ODD, -32768, -32768, -32768, -32768,
                            ST_WAIT, 1, 0, LVL_NORMAL, CODE_NONE, 0, 0, 98304));
    directed_rows.push_back(pinned_row(PLUG_PAID, 100, -100, 100, 32767,
                            ST_CHARGING, 1, 0, LVL_NORMAL, CODE_NONE, 0, 0, 300));
    directed_rows.push_back(pinned_row(PLUG_PAID, 300, 300, -300, 4000,
                            ST_CHARGING, 0, 1, LVL_NORMAL, CODE_NONE, 1, 1, 900));
    directed_rows.push_back(pinned_row(PLUG_PAID, 800, 800, -800, 0,
                            ST_CHARGING, 0, 1, LVL_NORMAL, CODE_NONE, 2, 2, 2400));
    directed_rows.push_back(tick_row(PLUG_PAID, 12, -7, 3, 230));
    directed_rows.push_back(tick_row(PLUG_PAID, 500, -400, 600, 3999));
    directed_rows.push_back(tick_row(PLUG_NONE, 1, 1, 1, 0));
    directed_rows.push_back(tick_row(PLUG_UNPAID, 0, 0, 0, 0));
    directed_rows.push_back(tick_row(PLUG_NONE, 0, 0, 0, 0));
    directed_rows.push_back(tick_row(PLUG_NONE, 7, 7, 7, -5));
    directed_rows.push_back(write_row(REG_UNDER_CURRENT, 16'd200));
    directed_rows.push_back(write_row(REG_RAMP_LENGTH, 16'd2));
    directed_rows.push_back(write_row(REG_TIME_LIMIT, 16'd3));
    directed_rows.push_back(tick_row(PLUG_PAID, 0, 0, 0, 0));
    directed_rows.push_back(tick_row(PLUG_PAID, 0, 0, 0, 0));
    directed_rows.push_back(pinned_row(PLUG_PAID, 0, 0, 0, 0,
                            ST_CHARGING, 0, 1, LVL_DETECT, CODE_UNDER_CURRENT, 1, 1, 0));
    directed_rows.push_back(tick_row(PLUG_PAID, 10, 10, 10, 0));
    directed_rows.push_back(tick_row(PLUG_PAID, 40, -30, 30, 0));
    directed_rows.push_back(tick_row(PLUG_PAID, 5, 5, 5, 0));
    directed_rows.push_back(tick_row(PLUG_PAID, 0, 0, 0, 0));
    directed_rows.push_back(tick_row(PLUG_NONE, 0, 0, 0, 0));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      int stall;
      stall = rx_quiet ? 0 : int'($urandom_range(0, 10));
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) check_result();
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    tick_result_t want_r;
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.plug_status <= PLUG_NONE;
    req_if.current_a   <= '0;
    req_if.current_b   <= '0;
    req_if.current_c   <= '0;
    req_if.voltage_a   <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= REG_OVER_CURRENT;
    cfg_if.data        <= '0;
    mismatches   = 0;
    results_seen = 0;
    cycles       = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    plug_now     = PLUG_NONE;
    reset_charger_model();
    build_directed();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < directed_rows.size(); i++) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        if (i == 0 || directed_rows[i-1].kind != ROW_WRITE) settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        if (i == directed_rows.size() - 1 || directed_rows[i+1].kind != ROW_WRITE)
          cfg_if.valid <= 1'b0;
      end else begin
        want_r = advance_charger(directed_rows[i].tick);
        if (directed_rows[i].kind == ROW_PINNED) want_r = directed_rows[i].want;
        send_tick(directed_rows[i].tick, want_r);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      configure_phase(p);
      run_items(PHASE_ITEMS, 1'b1);
    end
    // last phase lets trips through, so the sequencer can end latched in reset
    configure_phase(PHASES);
    run_items(LATCH_ITEMS, 1'b0);

    settle();
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/csfm_pkg.sv
sv/csfm_if.sv
sv/charger_sequence_fault_monitor.sv
dv/charger_sequence_fault_monitor_tb.sv
